@@ rtl/dds_pkg.sv @@
package dds_pkg;

    // Width of the integer that is converted, and how many decimal digits are kept.
    localparam int VALUE_WIDTH = 32;
    localparam int MAX_DIGITS  = 10;

    localparam int BCD_W = 4 * MAX_DIGITS;
    localparam int CNT_W = $clog2(VALUE_WIDTH);
    localparam int POS_W = $clog2(MAX_DIGITS + 1);

    typedef logic [BCD_W-1:0] t_bcd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_TRIM,
        ST_EMIT
    } t_state;

    // Result of one shift-add-3 step on the BCD accumulator.
    typedef struct packed {
        t_bcd bcd;
        logic carry;
    } t_dabble;

endpackage

@@ rtl/decimal_digit_splitter.sv @@
// Splits a signed integer into its decimal digits and sends them out one transfer per digit,
// most significant first, each with its position (digit count down to 1), the digit magnitude,
// the sign of the input and a last flag on the units digit. Zero gives a single digit 0.
// Negative inputs, including the most negative value, are converted as their magnitude with
// the negative flag set. One item is handled at a time: after the input transfer the block
// runs VALUE_WIDTH shift-add-3 steps on a single shared BCD correction unit (one input bit per
// cycle), then strips the leading zero digits one at a time, then offers one result per digit.
// The input is ready only while the block is idle.
module decimal_digit_splitter (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [dds_pkg::VALUE_WIDTH-1:0] i_value,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [3:0]                            o_position,
    output logic [3:0]                            o_digit,
    output logic                                  o_negative,
    output logic                                  o_last
);
    import dds_pkg::*;

    t_state                 r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_mag, n_mag;
    t_bcd                   r_bcd, n_bcd;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [POS_W-1:0]       r_pos, n_pos;
    logic                   r_neg, n_neg;
    logic                   r_ovf, n_ovf;

    t_dabble                w_step;
    logic                   w_in_xfer;
    logic                   w_out_xfer;
    logic                   w_top_zero;
    logic                   w_pos_one;

    // The shared unit sees the accumulator and the next magnitude bit, MSB first.
    dds_dabble_step u_step (
        .i_bcd  (r_bcd),
        .i_bit  (r_mag[VALUE_WIDTH-1]),
        .o_step (w_step)
    );

    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_out_xfer = o_out_valid && i_out_ready;
    assign w_top_zero = (r_bcd[BCD_W-1 -: 4] == 4'd0);
    assign w_pos_one  = (r_pos == POS_W'(1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_CONVERT;
                end
            end
            ST_CONVERT: begin
                if (r_cnt == '0) begin
                    n_state = ST_TRIM;
                end
            end
            ST_TRIM: begin
                // Stop stripping at the first non-zero digit, at the units digit, or when
                // digits were lost above the kept range (the count then saturates).
                if (r_ovf || !w_top_zero || w_pos_one) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_out_ready && w_pos_one) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Handshake and result outputs.
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE:    o_in_ready  = 1'b1;
            ST_EMIT:    o_out_valid = 1'b1;
            default: begin
                o_in_ready  = 1'b0;
                o_out_valid = 1'b0;
            end
        endcase
        o_position = 4'(r_pos);
        o_digit    = r_bcd[BCD_W-1 -: 4];
        o_negative = r_neg;
        o_last     = w_pos_one;
    end

    // Datapath next values.
    always_comb begin
        n_mag = r_mag;
        n_bcd = r_bcd;
        n_cnt = r_cnt;
        n_pos = r_pos;
        n_neg = r_neg;
        n_ovf = r_ovf;
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_neg = i_value[VALUE_WIDTH-1];
                    // Unsigned negate, so the most negative value yields its true magnitude.
                    n_mag = i_value[VALUE_WIDTH-1] ? (~i_value + 1'b1) : i_value;
                    n_bcd = '0;
                    n_cnt = CNT_W'(VALUE_WIDTH - 1);
                    n_ovf = 1'b0;
                end
            end
            ST_CONVERT: begin
                n_bcd = w_step.bcd;
                n_mag = {r_mag[VALUE_WIDTH-2:0], 1'b0};
                n_ovf = r_ovf | w_step.carry;
                n_cnt = r_cnt - 1'b1;
                n_pos = POS_W'(MAX_DIGITS);
            end
            ST_TRIM: begin
                if (!r_ovf && w_top_zero && !w_pos_one) begin
                    n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
                    n_pos = r_pos - 1'b1;
                end
            end
            ST_EMIT: begin
                if (w_out_xfer) begin
                    n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
                    n_pos = r_pos - 1'b1;
                end
            end
            default: begin
                n_bcd = r_bcd;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
        r_bcd <= n_bcd;
        r_cnt <= n_cnt;
        r_pos <= n_pos;
        r_neg <= n_neg;
        r_ovf <= n_ovf;
    end

endmodule

@@ rtl/dds_dabble_step.sv @@
module dds_dabble_step (
    input  dds_pkg::t_bcd    i_bcd,
    input  logic             i_bit,
    output dds_pkg::t_dabble o_step
);
    import dds_pkg::*;

    t_bcd w_adj;

    // Every digit of five or more gets three added, so that the shift doubles it in decimal.
    always_comb begin
        for (int d = 0; d < MAX_DIGITS; d++) begin
            if (i_bcd[4*d +: 4] >= 4'd5) begin
                w_adj[4*d +: 4] = i_bcd[4*d +: 4] + 4'd3;
            end else begin
                w_adj[4*d +: 4] = i_bcd[4*d +: 4];
            end
        end
    end

    assign o_step.bcd   = {w_adj[BCD_W-2:0], i_bit};
    assign o_step.carry = w_adj[BCD_W-1];

endmodule

@@ rtl/dds_checker.sv @@
module dds_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  o_in_ready,
    input logic signed [dds_pkg::VALUE_WIDTH-1:0] i_value,
    input logic                                  o_out_valid,
    input logic                                  i_out_ready,
    input logic [3:0]                            o_position,
    input logic [3:0]                            o_digit,
    input logic                                  o_negative,
    input logic                                  o_last
);
    import dds_pkg::*;

    // One item at a time: the input is never open while a result is on offer.
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is offered");

    // Conversion lies between an input transfer and any result, so no result follows it directly.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_out_valid)
        else $error("result offered straight after an input transfer");

    // The last flag marks exactly the units digit, and digits are decimal.
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_last == (o_position == 4'd1)) && (o_digit <= 4'd9)))
        else $error("bad last flag or digit");

    // After a non-last transfer the next position is one lower, same sign.
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last) |=>
        (o_out_valid && (o_position == 4'($past(o_position) - 4'd1))
         && (o_negative == $past(o_negative))))
        else $error("digit sequence broken");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_position) && $stable(o_digit) && $stable(o_last)))
        else $error("stalled result changed");

endmodule

bind decimal_digit_splitter dds_checker u_dds_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_value     (i_value),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_position  (o_position),
    .o_digit     (o_digit),
    .o_negative  (o_negative),
    .o_last      (o_last)
);
